// ----- hw/rtl/pidfr_pkg.sv -----
package pidfr_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int FRAC_BITS  = 16;
	localparam int ACC_W      = 48;
	localparam int GAIN_W     = 32;
	localparam int TOTAL_W    = 64;
	localparam int MUL_W      = 33;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FF_GAIN       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIM  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIM    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLDS    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_ON_MEAS = 3'd7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL_P,
		ST_MUL_D,
		ST_MUL_F,
		ST_MUL_T,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_ACC,
		ST_MUL_IH,
		ST_MUL_IL,
		ST_FIN,
		ST_OUT
	} state_t;

endpackage

// ----- hw/rtl/pid_controller_feature_rich_top.sv -----
// PID controller with feedforward, dead zone, variable-speed integration,
// integral separation and output clamp. Q16.16 gains.
// Input channel: in_valid/in_stall carries target and measurement, one word
// per control tick. Output channel: out_valid/out_stall carries drive and
// integral_sum, one word per input word.
// Configuration: cfg_we writes cfg_data into register cfg_index;
// write only while the block is idle.
// One multiplier (33x33, registered product) is stepped through the
// proportional, derivative, feedforward, taper and two integral products.
// When the error lies in the taper band, a bit-serial divider runs between the
// taper product and the integral update. The block holds in_stall high from
// accept until the result is registered and takes the next word once it is
// back in idle: a word is not taken before the last one is through.
// A result waits in the output register while out_stall is high; the next
// word is accepted meanwhile and its result is held back until the output
// register is free.
// Reset clears all gains, limits, the integral sum and the previous samples.
module pid_controller_feature_rich_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [pidfr_pkg::SAMPLE_W-1:0] target,
	input  logic signed [pidfr_pkg::SAMPLE_W-1:0] measurement,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [31:0]                  drive,
	output logic signed [pidfr_pkg::ACC_W-1:0]  integral_sum,
	input  logic                                cfg_we,
	input  logic [pidfr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pidfr_pkg::CFG_DATA_W-1:0]    cfg_data
);

	pidfr_pkg::state_t state_q, state_d;

	logic signed [31:0] kp_q, ki_q, kd_q, kf_q;
	logic [46:0]        ilim_q;
	logic [30:0]        olim_q;
	logic [63:0]        thr_q;
	logic               dmeas_q;

	logic signed [47:0] acc_q;
	logic signed [15:0] prev_t_q, prev_m_q;
	logic signed [16:0] prev_e_q;

	logic signed [15:0] t_q, m_q;
	logic signed [16:0] e_q;
	logic [15:0]        ae_q;
	logic               full_q, taper_q, sep_q;
	logic signed [65:0] prod_q;
	logic signed [63:0] total_q;
	logic signed [31:0] drive_q;
	logic signed [47:0] isum_q;
	logic               out_valid_q;

	logic [15:0] dz, sa, sb, sep;
	logic signed [16:0] e_w;
	logic [16:0]        ae_w;
	logic               dead;
	logic [16:0]        sab;
	logic signed [47:0] acc_clamp;
	logic signed [47:0] lim_pos, lim_neg;
	logic signed [32:0] op_a, op_b;
	logic signed [33:0] inc;
	logic signed [49:0] acc_sum;
	logic signed [47:0] acc_next;
	logic signed [65:0] it_hi;
	logic signed [31:0] drive_w;
	logic signed [31:0] olim_s;
	logic               div_start, div_done;
	logic [47:0]        div_quo;
	logic signed [17:0] taper_span;

	localparam logic signed [65:0] TERM_CAP = 66'sd1 <<< 61;
	localparam logic signed [63:0] D_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] D_MIN = -64'sh0000_0000_8000_0000;
	localparam logic signed [49:0] A_MAX = 50'sh0_7FFF_FFFF_FFFF;
	localparam logic signed [49:0] A_MIN = -50'sh0_8000_0000_0000;

	assign dz  = thr_q[15:0];
	assign sa  = thr_q[31:16];
	assign sb  = thr_q[47:32];
	assign sep = thr_q[63:48];

	always_comb begin
		e_w     = {t_q[15], t_q} - {m_q[15], m_q};
		ae_w    = e_w[16] ? 17'(-e_w) : 17'(e_w);
		dead    = ae_w < {1'b0, dz};
		sab     = {1'b0, sa} + {1'b0, sb};
		lim_pos = $signed({1'b0, ilim_q});
		lim_neg = -lim_pos;
		acc_clamp = acc_q;
		if (ilim_q != '0) begin
			if (acc_q > lim_pos) acc_clamp = lim_pos;
			if (acc_q < lim_neg) acc_clamp = lim_neg;
		end
		taper_span = $signed({2'b00, sab[15:0]}) + $signed({17'd0, sab[16]} << 16)
			- $signed({2'b00, ae_q});
	end

	// shared multiplier operand select
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			pidfr_pkg::ST_MUL_P: begin
				op_a = 33'(kp_q);
				op_b = 33'(e_q);
			end
			pidfr_pkg::ST_MUL_D: begin
				op_a = 33'(kd_q);
				if (dmeas_q)
					op_b = 33'(prev_m_q) - 33'(m_q);
				else
					op_b = 33'(e_q) - 33'(prev_e_q);
			end
			pidfr_pkg::ST_MUL_F: begin
				op_a = 33'(kf_q);
				op_b = 33'(t_q) - 33'(prev_t_q);
			end
			pidfr_pkg::ST_MUL_T: begin
				op_a = $signed({17'd0, ae_q});
				op_b = 33'(taper_span);
			end
			pidfr_pkg::ST_MUL_IH: begin
				op_a = 33'(ki_q);
				op_b = 33'($signed(acc_q[47:16]));
			end
			pidfr_pkg::ST_MUL_IL: begin
				op_a = 33'(ki_q);
				op_b = $signed({17'd0, acc_q[15:0]});
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_comb begin
		if (full_q)
			inc = 34'($signed({e_q, 16'd0}));
		else if (taper_q)
			inc = e_q[16] ? -$signed({1'b0, div_quo[32:0]}) : $signed({1'b0, div_quo[32:0]});
		else
			inc = '0;
		acc_sum = 50'(acc_q) + 50'(inc);
		if (sep_q)
			acc_next = '0;
		else if (acc_sum > A_MAX)
			acc_next = A_MAX[47:0];
		else if (acc_sum < A_MIN)
			acc_next = A_MIN[47:0];
		else
			acc_next = acc_sum[47:0];

		if (prod_q > TERM_CAP)
			it_hi = TERM_CAP;
		else if (prod_q < -TERM_CAP)
			it_hi = -TERM_CAP;
		else
			it_hi = prod_q;

		if (total_q > D_MAX)
			drive_w = D_MAX[31:0];
		else if (total_q < D_MIN)
			drive_w = D_MIN[31:0];
		else
			drive_w = total_q[31:0];
		olim_s = $signed({1'b0, olim_q});
		if (olim_q != '0) begin
			if (drive_w > olim_s) drive_w = olim_s;
			if (drive_w < -olim_s) drive_w = -olim_s;
		end
	end

	assign div_start = state_q == pidfr_pkg::ST_DIV_START;

	pidfr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({prod_q[31:0], 16'd0}),
		.divisor  (sb),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= pidfr_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pidfr_pkg::ST_IDLE:      if (in_valid) state_d = pidfr_pkg::ST_PREP;
			pidfr_pkg::ST_PREP:      state_d = pidfr_pkg::ST_MUL_P;
			pidfr_pkg::ST_MUL_P:     state_d = pidfr_pkg::ST_MUL_D;
			pidfr_pkg::ST_MUL_D:     state_d = pidfr_pkg::ST_MUL_F;
			pidfr_pkg::ST_MUL_F:     state_d = pidfr_pkg::ST_MUL_T;
			pidfr_pkg::ST_MUL_T: begin
				state_d = taper_q ? pidfr_pkg::ST_DIV_START : pidfr_pkg::ST_ACC;
			end
			pidfr_pkg::ST_DIV_START: state_d = pidfr_pkg::ST_DIV_WAIT;
			pidfr_pkg::ST_DIV_WAIT:  if (div_done) state_d = pidfr_pkg::ST_ACC;
			pidfr_pkg::ST_ACC:       state_d = pidfr_pkg::ST_MUL_IH;
			pidfr_pkg::ST_MUL_IH:    state_d = pidfr_pkg::ST_MUL_IL;
			pidfr_pkg::ST_MUL_IL:    state_d = pidfr_pkg::ST_FIN;
			pidfr_pkg::ST_FIN:       state_d = pidfr_pkg::ST_OUT;
			pidfr_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall) state_d = pidfr_pkg::ST_IDLE;
			end
			default:                 state_d = pidfr_pkg::ST_IDLE;
		endcase
	end

	assign in_stall = state_q != pidfr_pkg::ST_IDLE;

	// configuration, accumulator, history, output flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q        <= '0;
			ki_q        <= '0;
			kd_q        <= '0;
			kf_q        <= '0;
			ilim_q      <= '0;
			olim_q      <= '0;
			thr_q       <= '0;
			dmeas_q     <= 1'b0;
			acc_q       <= '0;
			prev_t_q    <= '0;
			prev_m_q    <= '0;
			prev_e_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					pidfr_pkg::REG_PROP_GAIN:     kp_q    <= cfg_data[31:0];
					pidfr_pkg::REG_INTEGRAL_GAIN: ki_q    <= cfg_data[31:0];
					pidfr_pkg::REG_DERIV_GAIN:    kd_q    <= cfg_data[31:0];
					pidfr_pkg::REG_FF_GAIN:       kf_q    <= cfg_data[31:0];
					pidfr_pkg::REG_INTEGRAL_LIM:  ilim_q  <= cfg_data[46:0];
					pidfr_pkg::REG_OUTPUT_LIM:    olim_q  <= cfg_data[30:0];
					pidfr_pkg::REG_THRESHOLDS:    thr_q   <= cfg_data;
					pidfr_pkg::REG_DERIV_ON_MEAS: dmeas_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (state_q == pidfr_pkg::ST_OUT && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				pidfr_pkg::ST_PREP: acc_q <= acc_clamp;
				pidfr_pkg::ST_ACC:  acc_q <= acc_next;
				pidfr_pkg::ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						prev_t_q    <= t_q;
						prev_m_q    <= m_q;
						prev_e_q    <= e_q;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			pidfr_pkg::ST_IDLE: begin
				if (in_valid) begin
					t_q <= target;
					m_q <= measurement;
				end
			end
			pidfr_pkg::ST_PREP: begin
				e_q  <= dead ? '0 : e_w;
				ae_q <= dead ? '0 : ae_w[15:0];
				if (dead) t_q <= m_q;
				full_q  <= ((sa == '0) && (sb == '0)) || dead || (ae_w < {1'b0, sa});
				taper_q <= !dead && (ae_w >= {1'b0, sa}) && (ae_w < sab)
					&& !((sa == '0) && (sb == '0));
				sep_q   <= !dead && (sep != '0) && (ae_w >= {1'b0, sep});
			end
			pidfr_pkg::ST_MUL_P: prod_q <= op_a * op_b;
			pidfr_pkg::ST_MUL_D: begin
				total_q <= prod_q[63:0];
				prod_q  <= op_a * op_b;
			end
			pidfr_pkg::ST_MUL_F, pidfr_pkg::ST_MUL_T: begin
				total_q <= total_q + prod_q[63:0];
				prod_q  <= op_a * op_b;
			end
			pidfr_pkg::ST_MUL_IH: prod_q <= op_a * op_b;
			pidfr_pkg::ST_MUL_IL: begin
				total_q <= total_q + it_hi[63:0];
				prod_q  <= op_a * op_b;
			end
			pidfr_pkg::ST_FIN: total_q <= total_q + 64'(prod_q >>> pidfr_pkg::FRAC_BITS);
			pidfr_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					drive_q <= drive_w;
					isum_q  <= acc_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign drive        = drive_q;
	assign integral_sum = isum_q;

endmodule

// ----- hw/rtl/pidfr_div.sv -----
module pidfr_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [47:0] quotient
);

	logic [15:0] rem_q;
	logic [47:0] quo_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] rem_sh;
	logic        take;
	logic [16:0] rem_sub;

	always_comb begin
		rem_sh  = {rem_q, quo_q[47]};
		take    = rem_sh >= {1'b0, divisor};
		rem_sub = rem_sh - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd47;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= take ? rem_sub[15:0] : rem_sh[15:0];
			quo_q <= {quo_q[46:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- bench/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [pidfr_pkg::SAMPLE_W-1:0] tgt;
		logic signed [pidfr_pkg::SAMPLE_W-1:0] meas;
	} tick_t;

	typedef struct {
		logic signed [31:0]                 drv;
		logic signed [pidfr_pkg::ACC_W-1:0] acc;
	} ctl_out_t;

	localparam longint TERM_CAP = 64'sh2000_0000_0000_0000;
	localparam longint ACC_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint ACC_MIN  = -ACC_MAX - 1;
	localparam int     CYCLE_LIMIT = 1000000;

	logic                                  clk = 1'b0;
	logic                                  arst_n = 1'b0;
	logic                                  in_valid = 1'b0;
	logic                                  in_stall;
	logic signed [pidfr_pkg::SAMPLE_W-1:0] target = '0;
	logic signed [pidfr_pkg::SAMPLE_W-1:0] measurement = '0;
	logic                                  out_valid;
	logic                                  out_stall = 1'b0;
	logic signed [31:0]                    drive;
	logic signed [pidfr_pkg::ACC_W-1:0]    integral_sum;
	logic                                  cfg_we = 1'b0;
	logic [pidfr_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
	logic [pidfr_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

	pid_controller_feature_rich_top DUT (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// controller model state and registers
	longint      kp, ki, kd, kf, int_lim, out_lim;
	logic [63:0] thresholds;
	bit          d_on_meas;
	longint      acc_sum, prev_tgt, prev_meas, prev_err;

	tick_t    ticks_pending[$];
	ctl_out_t drive_expected[$];
	int       errors = 0;
	int       cycles = 0;
	bit       calm = 0;

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	function automatic longint sat_product(input longint x, input longint y);
		longint unsigned mx, my, mag;
		mx = x < 0 ? -x : x;
		my = y < 0 ? -y : y;
		if (mx != 0 && my > longint'(TERM_CAP) / mx)
			mag = TERM_CAP;
		else
			mag = mx * my;
		return ((x < 0) != (y < 0)) ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic void model_write(input logic [pidfr_pkg::CFG_IDX_W-1:0] idx,
		input logic [63:0] d);
		case (idx)
			pidfr_pkg::REG_PROP_GAIN:     kp = $signed(d[31:0]);
			pidfr_pkg::REG_INTEGRAL_GAIN: ki = $signed(d[31:0]);
			pidfr_pkg::REG_DERIV_GAIN:    kd = $signed(d[31:0]);
			pidfr_pkg::REG_FF_GAIN:       kf = $signed(d[31:0]);
			pidfr_pkg::REG_INTEGRAL_LIM:  int_lim = d[46:0];
			pidfr_pkg::REG_OUTPUT_LIM:    out_lim = d[30:0];
			pidfr_pkg::REG_THRESHOLDS:    thresholds = d;
			pidfr_pkg::REG_DERIV_ON_MEAS: d_on_meas = d[0];
			default: ;
		endcase
	endfunction

	function automatic ctl_out_t compute_drive(input tick_t w);
		longint t, m, e, ae, dz, sa, sb, sep, inc, ah, al, pt, it, dt, ft, total, mag;
		longint unsigned num;
		ctl_out_t r;
		t = w.tgt;
		m = w.meas;
		dz = thresholds[15:0];
		sa = thresholds[31:16];
		sb = thresholds[47:32];
		sep = thresholds[63:48];
		e = t - m;
		ae = e < 0 ? -e : e;
		if (ae < dz) begin
			t = m;
			e = 0;
			ae = 0;
		end
		pt = kp * e;
		if ((sa == 0 && sb == 0) || ae < sa) begin
			inc = e * 65536;
		end else if (ae < sa + sb) begin
			num = longint'(ae) * longint'(sa + sb - ae) * 65536;
			mag = num / longint'(sb);
			inc = e < 0 ? -mag : mag;
		end else begin
			inc = 0;
		end
		if (int_lim != 0) begin
			if (acc_sum > int_lim) acc_sum = int_lim;
			if (acc_sum < -int_lim) acc_sum = -int_lim;
		end
		if (sep == 0 || ae < sep) begin
			acc_sum += inc;
			if (acc_sum > ACC_MAX) acc_sum = ACC_MAX;
			if (acc_sum < ACC_MIN) acc_sum = ACC_MIN;
		end else begin
			acc_sum = 0;
		end
		ah = acc_sum >>> pidfr_pkg::FRAC_BITS;
		al = acc_sum - (ah <<< pidfr_pkg::FRAC_BITS);
		it = sat_product(ki, ah) + ((ki * al) >>> pidfr_pkg::FRAC_BITS);
		dt = d_on_meas ? kd * (prev_meas - m) : kd * (e - prev_err);
		ft = (t - prev_tgt) * kf;
		total = pt + it + dt + ft;
		if (total > 64'sh7FFF_FFFF) total = 64'sh7FFF_FFFF;
		if (total < -64'sh8000_0000) total = -64'sh8000_0000;
		if (out_lim != 0) begin
			if (total > out_lim) total = out_lim;
			if (total < -out_lim) total = -out_lim;
		end
		prev_meas = m;
		prev_tgt = t;
		prev_err = e;
		r.drv = total[31:0];
		r.acc = acc_sum[pidfr_pkg::ACC_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin : feed_p
		tick_t    nx;
		ctl_out_t r;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end else if (arst_n) begin
			if (in_valid && !in_stall) begin
				nx.tgt = target;
				nx.meas = measurement;
				r = compute_drive(nx);
				drive_expected.push_back(r);
			end
			if (!in_valid || !in_stall) begin
				if (ticks_pending.size() > 0 && (calm || $urandom_range(99) >= 15)) begin
					nx = ticks_pending.pop_front();
					in_valid <= 1'b1;
					target <= nx.tgt;
					measurement <= nx.meas;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_p
		ctl_out_t x;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (drive_expected.size() == 0) begin
					report_mismatch("result word with nothing outstanding");
				end else begin
					x = drive_expected.pop_front();
					if (drive !== x.drv)
						report_mismatch($sformatf("drive %0d, want %0d", drive, x.drv));
					if (integral_sum !== x.acc)
						report_mismatch($sformatf("integral_sum %0d, want %0d",
							integral_sum, x.acc));
				end
			end
			out_stall <= calm ? 1'b0 : ($urandom_range(99) < 15);
		end
	end

	task automatic write_reg(input logic [pidfr_pkg::CFG_IDX_W-1:0] idx,
		input logic [63:0] d);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		model_write(idx, d);
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (ticks_pending.size() > 0 || in_valid || drive_expected.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic add_tick(input int t, input int m);
		tick_t w;
		w.tgt = 16'(t);
		w.meas = 16'(m);
		ticks_pending.push_back(w);
	endtask

	function automatic logic [63:0] rand_gain();
		if ($urandom_range(3) == 0)
			return {32'b0, $urandom()};
		return {32'b0, 32'($urandom_range(32'h40000) - 32'h20000)};
	endfunction

	function automatic int clamp_sample(input int v);
		return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
	endfunction

	initial begin : stim_p
		int span, m, p;
		logic [63:0] lim;
		kp = 0; ki = 0; kd = 0; kf = 0; int_lim = 0; out_lim = 0;
		thresholds = '0; d_on_meas = 0;
		acc_sum = 0; prev_tgt = 0; prev_meas = 0; prev_err = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset values
		add_tick(100, -50);
		add_tick(-32768, 32767);
		add_tick(32767, -32768);
		drain();

		// dead zone 4, A 100, band B 200, separation 20000
		write_reg(pidfr_pkg::REG_PROP_GAIN, 64'h10000);
		write_reg(pidfr_pkg::REG_INTEGRAL_GAIN, 64'h800);
		write_reg(pidfr_pkg::REG_DERIV_GAIN, 64'h2000);
		write_reg(pidfr_pkg::REG_FF_GAIN, 64'h4000);
		write_reg(pidfr_pkg::REG_INTEGRAL_LIM, 64'h1_0000_0000);
		write_reg(pidfr_pkg::REG_OUTPUT_LIM, 64'h0);
		write_reg(pidfr_pkg::REG_THRESHOLDS, {16'd20000, 16'd200, 16'd100, 16'd4});
		write_reg(pidfr_pkg::REG_DERIV_ON_MEAS, 64'h0);
		end_writes();
		add_tick(2, 0);        // inside dead zone
		add_tick(-3, 0);
		add_tick(4, 0);        // dead zone edge
		add_tick(50, 0);       // full speed
		add_tick(-99, 0);
		add_tick(100, 0);      // taper start
		add_tick(-200, 0);     // inside taper
		add_tick(299, 0);
		add_tick(300, 0);      // beyond band
		add_tick(20000, 0);    // separation
		add_tick(-19999, 0);
		add_tick(32767, -32768);
		add_tick(-32768, 32767);
		add_tick(0, 0);
		drain();

		// extremes: full-scale gains and limits, derivative on measurement
		write_reg(pidfr_pkg::REG_PROP_GAIN, 64'h7FFF_FFFF);
		write_reg(pidfr_pkg::REG_INTEGRAL_GAIN, 64'h8000_0000);
		write_reg(pidfr_pkg::REG_DERIV_GAIN, 64'h7FFF_FFFF);
		write_reg(pidfr_pkg::REG_FF_GAIN, 64'h8000_0000);
		write_reg(pidfr_pkg::REG_INTEGRAL_LIM, 64'h7FFF_FFFF_FFFF);
		write_reg(pidfr_pkg::REG_OUTPUT_LIM, 64'h7FFF_FFFF);
		write_reg(pidfr_pkg::REG_THRESHOLDS, {16'h0, 16'h0, 16'hFFFF, 16'h0});
		write_reg(pidfr_pkg::REG_DERIV_ON_MEAS, 64'h1);
		end_writes();
		for (int i = 0; i < 4; i++) begin
			add_tick(32767, -32768);
			add_tick(-32768, 32767);
		end
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			calm = (ph == 3);
			if (ph == 7) begin
				write_reg(pidfr_pkg::REG_OUTPUT_LIM, 64'h1);
				write_reg(pidfr_pkg::REG_THRESHOLDS, 64'hFFFF_FFFF_FFFF_FFFF);
			end else begin
				case ($urandom_range(3))
					0: lim = 0;
					1: lim = 64'($urandom_range(1, 32'h100_0000));
					2: lim = {$urandom(), $urandom()} & 64'h7FFF_FFFF_FFFF;
					default: lim = {$urandom_range(32'h7FFF), $urandom()};
				endcase
				write_reg(pidfr_pkg::REG_INTEGRAL_LIM, lim);
				write_reg(pidfr_pkg::REG_OUTPUT_LIM,
					$urandom_range(1) ? 64'h0 : {32'b0, $urandom()});
				write_reg(pidfr_pkg::REG_THRESHOLDS, {
					16'($urandom_range(1) ? 0 : $urandom_range(200, 65535)),
					16'($urandom_range(1, 1000)),
					16'($urandom_range(500)),
					16'($urandom_range(20))});
			end
			write_reg(pidfr_pkg::REG_PROP_GAIN, rand_gain());
			write_reg(pidfr_pkg::REG_INTEGRAL_GAIN, rand_gain());
			write_reg(pidfr_pkg::REG_DERIV_GAIN, rand_gain());
			write_reg(pidfr_pkg::REG_FF_GAIN, rand_gain());
			write_reg(pidfr_pkg::REG_DERIV_ON_MEAS, 64'($urandom_range(1)));
			end_writes();
			span = int'(thresholds[31:16]) + int'(thresholds[47:32]) + 100;
			for (int i = 0; i < 110; i++) begin
				if ($urandom_range(99) < 30) begin
					add_tick($signed(16'($urandom())), $signed(16'($urandom())));
				end else begin
					m = $signed(16'($urandom()));
					p = int'($urandom_range(2 * span)) - span;
					add_tick(clamp_sample(m + p), m);
				end
			end
			drain();
		end
		calm = 0;

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/pidfr_pkg.sv
hw/rtl/pidfr_div.sv
hw/rtl/pid_controller_feature_rich_top.sv
bench/tb.sv
